// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL of the recency list.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold on every clock edge out of reset.
`define LRUT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define LRUT_ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/lrut_pkg.sv -----
// Constants and types shared by the recency list modules.
package lrut_pkg;

	localparam int ENTRIES   = 64;
	localparam int IDX_W     = $clog2(ENTRIES);
	localparam int CNT_W     = IDX_W + 1;
	localparam int FRAME_W   = 8;
	localparam int CMD_W     = 2;
	localparam int CAP_W     = 7;

	localparam logic [CMD_W-1:0] CMD_UNPIN  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PIN    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd2;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	// Control broadcast from the top level to every slot of the row.
	typedef struct packed {
		logic               en;
		logic               ins;
		logic               rem;
		logic [IDX_W-1:0]   rm_idx;
		logic [CNT_W-1:0]   new_count;
		logic [FRAME_W-1:0] key;
	} cell_ctl_t;

endpackage

// ----- hw/rtl/lrut_cmd_if.sv -----
// Command channel: an operation and the frame it applies to.
interface lrut_cmd_if import lrut_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [FRAME_W-1:0] frame_no;

	modport source (output valid, command, frame_no, input ready);
	modport sink   (input valid, command, frame_no, output ready);
endinterface

// ----- hw/rtl/lrut_rsp_if.sv -----
// Response channel: outcome, evicted frame and the entry count.
interface lrut_rsp_if import lrut_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               success;
	logic [FRAME_W-1:0] victim_frame;
	logic [CNT_W-1:0]   entry_count;

	modport source (output valid, success, victim_frame, entry_count, input ready);
	modport sink   (input valid, success, victim_frame, entry_count, output ready);
endinterface

// ----- hw/rtl/lrut_cell.sv -----
// One slot of the recency row: holds a frame, matches it and shifts with its neighbours.
module lrut_cell import lrut_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [IDX_W-1:0]   idx,
	input  cell_ctl_t          ctl,
	input  logic [FRAME_W-1:0] left_frame,
	input  logic [FRAME_W-1:0] right_frame,
	input  logic               right_valid,
	output logic [FRAME_W-1:0] frame_q,
	output logic               valid_q,
	output logic               hit,
	output logic               tail
);

	assign hit  = valid_q && (frame_q == ctl.key);
	// The oldest entry is the last valid slot, before an empty one or at the end of the row.
	assign tail = valid_q && !right_valid;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			if (ctl.ins) begin
				frame_q <= left_frame;
			end else if (ctl.rem && (idx >= ctl.rm_idx)) begin
				frame_q <= right_frame;
			end
		end
	end

	// Valid slots always form a prefix of the row, so the new count decides each bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.en) begin
			valid_q <= ({1'b0, idx} < ctl.new_count);
		end
	end

endmodule

// ----- hw/rtl/lru_replacer_table_top.sv -----
// Top level of the recency list: row of slots, command decode and response register.
//
//   channel   dir   handshake        payload
//   cmd       in    valid/ready      command, frame_no
//   rsp       out   valid/ready      success, victim_frame, entry_count
//   cfg       in    cfg_we           cfg_wdata (capacity)
//
// Each item is decoded and applied to the whole row as it is accepted, one item per cycle
// unless a response stalls; the response appears in the cycle after acceptance.
// The response register frees up as it is taken, so a new item enters while the
// previous response is being taken; a stalled response holds off the next item.
// Reset empties the list and sets the capacity to 64 at once; no clearing pass.
module lru_replacer_table_top import lrut_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	lrut_cmd_if.sink          cmd,
	lrut_rsp_if.source        rsp,
	input  logic              cfg_we,
	input  logic [CAP_W-1:0]  cfg_wdata
);

	logic [CAP_W-1:0]   capacity_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   eff_cap;
	logic               accept;
	logic               victim_pop;

	logic               rsp_valid_q;
	logic               success_q;
	logic [FRAME_W-1:0] victim_q;
	logic [CNT_W-1:0]   entry_count_q;

	logic [FRAME_W-1:0] frame_vec [ENTRIES];
	logic [ENTRIES-1:0] valid_vec;
	logic [ENTRIES-1:0] hit_vec;
	logic [ENTRIES-1:0] tail_vec;

	logic               any_hit;
	logic [IDX_W-1:0]   hit_idx;
	logic [FRAME_W-1:0] tail_frame;
	logic [CNT_W-1:0]   count_dec;

	cell_ctl_t          ctl;
	logic               ok;
	logic [FRAME_W-1:0] victim_d;

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = !rsp_valid_q || rsp.ready;

	always_comb begin
		if (capacity_q == '0) begin
			eff_cap = CNT_W'(1);
		end else if (capacity_q > CAP_W'(ENTRIES)) begin
			eff_cap = CNT_W'(ENTRIES);
		end else begin
			eff_cap = CNT_W'(capacity_q);
		end
	end

	// Frames in the list are distinct, so at most one slot hits and one slot is the tail.
	always_comb begin
		hit_idx    = '0;
		tail_frame = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_idx    = hit_idx | (hit_vec[i] ? IDX_W'(i) : '0);
			tail_frame = tail_frame | (tail_vec[i] ? frame_vec[i] : '0);
		end
	end

	assign any_hit   = |hit_vec;
	assign count_dec = count_q - CNT_W'(1);

	always_comb begin
		ctl.en        = accept;
		ctl.ins       = 1'b0;
		ctl.rem       = 1'b0;
		ctl.rm_idx    = hit_idx;
		ctl.new_count = count_q;
		ctl.key       = cmd.frame_no;
		ok            = 1'b0;
		victim_d      = '0;
		unique case (cmd.command)
			CMD_UNPIN: begin
				if (!any_hit) begin
					ctl.ins = 1'b1;
					ok      = 1'b1;
					// A full list loses its oldest entry as the row shifts.
					if (count_q < eff_cap) begin
						ctl.new_count = count_q + CNT_W'(1);
					end
				end
			end
			CMD_PIN: begin
				if (any_hit) begin
					ctl.rem       = 1'b1;
					ctl.new_count = count_dec;
					ok            = 1'b1;
				end
			end
			CMD_VICTIM: begin
				if (count_q != '0) begin
					ctl.rem       = 1'b1;
					ctl.rm_idx    = count_dec[IDX_W-1:0];
					ctl.new_count = count_dec;
					victim_d      = tail_frame;
					ok            = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_row
		logic [FRAME_W-1:0] left_frame;
		logic [FRAME_W-1:0] right_frame;
		logic               right_valid;

		if (i == 0) begin : g_head
			assign left_frame = cmd.frame_no;
		end else begin : g_body
			assign left_frame = frame_vec[i-1];
		end

		if (i == ENTRIES - 1) begin : g_last
			assign right_frame = '0;
			assign right_valid = 1'b0;
		end else begin : g_inner
			assign right_frame = frame_vec[i+1];
			assign right_valid = valid_vec[i+1];
		end

		lrut_cell u_slot (
			.clk         (clk),
			.arst_n      (arst_n),
			.idx         (IDX_W'(i)),
			.ctl         (ctl),
			.left_frame  (left_frame),
			.right_frame (right_frame),
			.right_valid (right_valid),
			.frame_q     (frame_vec[i]),
			.valid_q     (valid_vec[i]),
			.hit         (hit_vec[i]),
			.tail        (tail_vec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAP_RESET;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we && (count_q == '0)) begin
				capacity_q <= cfg_wdata;
			end
			if (accept) begin
				count_q <= ctl.new_count;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			success_q     <= ok;
			victim_q      <= victim_d;
			entry_count_q <= ctl.new_count;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.success      = success_q;
	assign rsp.victim_frame = victim_q;
	assign rsp.entry_count  = entry_count_q;

	assign victim_pop = accept && (cmd.command == CMD_VICTIM) && (count_q != '0);

`include "assert_macros.svh"

	`LRUT_ASSERT(a_count_in_cap, count_q <= eff_cap, "entry count exceeds capacity")
	`LRUT_ASSERT(a_single_hit, $onehot0(hit_vec), "frame listed in more than one slot")
	`LRUT_ASSERT(a_valid_prefix, $countones(valid_vec) == 32'(count_q), "valid bits off count")
	`LRUT_ASSERT_NEXT(a_victim_pops, victim_pop, success_q && (count_q == $past(count_dec)), "no pop")

endmodule
